>>> design/rum_pkg.sv
// ----------------------------------------------------------------------------
// rum_pkg: shared types and constants of the RGB unsharp mask filter
// Holds the controller states, the command and status bundles between the
// controller and the datapath, and the configuration register indexes.
// ----------------------------------------------------------------------------
package rum_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADDR,
        ST_ACC,
        ST_KB,
        ST_GAIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic addr;
        logic acc;
        logic kb;
        logic gain;
        logic done;
    } dp_cmd_t;

    typedef struct packed {
        logic out_ready;
        logic tap_last;
    } dp_status_t;

    localparam logic [2:0] REG_BOUNDARY_MODE = 3'd0;
    localparam logic [2:0] REG_ROW_WEIGHTS   = 3'd1;
    localparam logic [2:0] REG_COL_WEIGHTS   = 3'd2;
    localparam logic [2:0] REG_SHARPEN_K     = 3'd3;
    localparam logic [2:0] REG_OUT_GAIN      = 3'd4;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd5;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd6;

    localparam logic MODE_ZERO_PAD = 1'b0;
    localparam logic MODE_MIRROR   = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

endpackage

>>> design/rum_ram.sv
// ----------------------------------------------------------------------------
// rum_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rum_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rum_ctrl.sv
// ----------------------------------------------------------------------------
// rum_ctrl: sequencing controller of the unsharp mask filter
// Takes one beat at a time, walks the datapath through the window taps and
// the sharpening steps, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module rum_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  rum_pkg::dp_status_t status,
    output rum_pkg::dp_cmd_t    cmd
);

    rum_pkg::state_t state_reg;
    rum_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rum_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rum_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rum_pkg::ST_CHECK;
                end
            end
            rum_pkg::ST_CHECK: begin
                state_next = status.out_ready ? rum_pkg::ST_ADDR : rum_pkg::ST_IDLE;
            end
            rum_pkg::ST_ADDR: state_next = rum_pkg::ST_ACC;
            rum_pkg::ST_ACC: begin
                state_next = status.tap_last ? rum_pkg::ST_KB : rum_pkg::ST_ADDR;
            end
            rum_pkg::ST_KB:   state_next = rum_pkg::ST_GAIN;
            rum_pkg::ST_GAIN: state_next = rum_pkg::ST_OUT;
            rum_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = rum_pkg::ST_IDLE;
                end
            end
            default: state_next = rum_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        case (state_reg)
            rum_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            rum_pkg::ST_CHECK: cmd.start = status.out_ready;
            rum_pkg::ST_ADDR:  cmd.addr  = 1'b1;
            rum_pkg::ST_ACC:   cmd.acc   = 1'b1;
            rum_pkg::ST_KB:    cmd.kb    = 1'b1;
            rum_pkg::ST_GAIN:  cmd.gain  = 1'b1;
            rum_pkg::ST_OUT: begin
                m_valid  = 1'b1;
                cmd.done = m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/rum_datapath.sv
// ----------------------------------------------------------------------------
// rum_datapath: line store, window accumulation and sharpening arithmetic
// Keeps the input and output raster positions, the ring of line buffers,
// one tap multiply-accumulate per channel and the sharpening pipeline.
// ----------------------------------------------------------------------------
module rum_datapath #(
    parameter int RADIUS     = 1,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rum_pkg::dp_cmd_t    cmd,
    output rum_pkg::dp_status_t status,
    input  logic                in_cmd,
    input  logic [23:0]         in_pix,
    input  logic                boundary_mode,
    input  logic [47:0]         row_weights,
    input  logic [47:0]         col_weights,
    input  logic [15:0]         sharpen_k,
    input  logic [23:0]         out_gain,
    input  logic [10:0]         image_width,
    input  logic [10:0]         image_height,
    output logic [7:0]          out_red,
    output logic [7:0]          out_green,
    output logic [7:0]          out_blue,
    output logic                frame_end
);

    localparam int RING  = 2 * RADIUS + 2;
    localparam int SW    = $clog2(RING);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int KW    = $clog2(2 * RADIUS + 1);
    localparam int NT    = (2 * RADIUS + 1) * (2 * RADIUS + 1);
    localparam int ACW   = 40 + $clog2(NT + 1);
    localparam int XW    = ((CW > RW) ? CW : RW) + 2;

    // Geometry, clamped to the supported range.
    logic [CW-1:0] width_c;
    logic [RW-1:0] height_c;

    always_comb begin
        if (image_width < 11'd3) begin
            width_c = CW'(3);
        end else if (13'(image_width) > 13'(MAX_WIDTH)) begin
            width_c = CW'(MAX_WIDTH);
        end else begin
            width_c = CW'(image_width);
        end
        if (image_height < 11'd3) begin
            height_c = RW'(3);
        end else if (13'(image_height) > 13'(MAX_HEIGHT)) begin
            height_c = RW'(MAX_HEIGHT);
        end else begin
            height_c = RW'(image_height);
        end
    end

    // Raster positions.
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [SW-1:0] in_slot_reg, in_slot_next;
    logic          frame_rcvd_reg, frame_rcvd_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;
    logic [SW-1:0] out_slot_reg, out_slot_next;
    logic          last_pos;
    logic          wr_en;

    assign last_pos = (out_row_reg == height_c - RW'(1)) && (out_col_reg == width_c - CW'(1));
    assign wr_en    = cmd.accept && (in_cmd == rum_pkg::CMD_PIXEL) && !frame_rcvd_reg;

    always_comb begin
        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        in_slot_next    = in_slot_reg;
        frame_rcvd_next = frame_rcvd_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_slot_next   = out_slot_reg;
        if (wr_en) begin
            if (in_col_reg + CW'(1) >= width_c) begin
                in_col_next = '0;
                if (in_row_reg + RW'(1) >= height_c) begin
                    in_row_next     = '0;
                    in_slot_next    = '0;
                    frame_rcvd_next = 1'b1;
                end else begin
                    in_row_next  = in_row_reg + RW'(1);
                    in_slot_next = (in_slot_reg == SW'(RING - 1)) ? '0 : in_slot_reg + SW'(1);
                end
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
        end
        if (cmd.done) begin
            if (last_pos) begin
                out_col_next    = '0;
                out_row_next    = '0;
                out_slot_next   = '0;
                in_col_next     = '0;
                in_row_next     = '0;
                in_slot_next    = '0;
                frame_rcvd_next = 1'b0;
            end else if (out_col_reg + CW'(1) >= width_c) begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + RW'(1);
                out_slot_next = (out_slot_reg == SW'(RING - 1)) ? '0 : out_slot_reg + SW'(1);
            end else begin
                out_col_next = out_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_slot_reg    <= '0;
            frame_rcvd_reg <= 1'b0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_slot_reg   <= '0;
        end else begin
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            in_slot_reg    <= in_slot_next;
            frame_rcvd_reg <= frame_rcvd_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
            out_slot_reg   <= out_slot_next;
        end
    end

    // The next output may go once its lower-right window corner has arrived.
    logic [RW:0] need_row;
    logic [CW:0] need_col;

    always_comb begin
        need_row = (RW + 1)'(out_row_reg) + (RW + 1)'(RADIUS);
        if (need_row > (RW + 1)'(height_c) - (RW + 1)'(1)) begin
            need_row = (RW + 1)'(height_c) - (RW + 1)'(1);
        end
        need_col = (CW + 1)'(out_col_reg) + (CW + 1)'(RADIUS);
        if (need_col > (CW + 1)'(width_c) - (CW + 1)'(1)) begin
            need_col = (CW + 1)'(width_c) - (CW + 1)'(1);
        end
    end

    assign status.out_ready = frame_rcvd_reg
        || ((RW + 1)'(in_row_reg) > need_row)
        || (((RW + 1)'(in_row_reg) == need_row) && ((CW + 1)'(in_col_reg) > need_col));

    // Tap sequencing: the center pixel first, then the window row by row.
    logic          center_reg;
    logic [KW-1:0] ai_reg;
    logic [KW-1:0] bi_reg;

    assign status.tap_last = !center_reg && (ai_reg == KW'(2 * RADIUS))
        && (bi_reg == KW'(2 * RADIUS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= 1'b0;
            ai_reg     <= '0;
            bi_reg     <= '0;
        end else if (cmd.start) begin
            center_reg <= 1'b1;
            ai_reg     <= '0;
            bi_reg     <= '0;
        end else if (cmd.acc) begin
            if (center_reg) begin
                center_reg <= 1'b0;
            end else if (bi_reg == KW'(2 * RADIUS)) begin
                bi_reg <= '0;
                ai_reg <= ai_reg + KW'(1);
            end else begin
                bi_reg <= bi_reg + KW'(1);
            end
        end
    end

    // Border handling: returns {ok, mapped coordinate}.
    function automatic logic [XW:0] map_coord(
        input logic signed [XW-1:0] p,
        input logic signed [XW-1:0] off,
        input logic signed [XW-1:0] n,
        input logic                 mode
    );
        logic signed [XW-1:0] t;
        logic                 ok;
        t  = p + off;
        ok = 1'b1;
        if (t < 0 || t > n - 1) begin
            if (mode == rum_pkg::MODE_ZERO_PAD) begin
                ok = 1'b0;
            end else begin
                t  = (t > n - 1) ? (p - off) : -(p + off);
                ok = !(t < 0 || t > n - 1);
            end
        end
        return {ok, t};
    endfunction

    function automatic logic [15:0] pick_weight(
        input logic [47:0]   weights,
        input logic [KW-1:0] idx
    );
        logic [1:0] tap_dist;
        tap_dist = (idx < KW'(RADIUS)) ? 2'(KW'(RADIUS) - idx) : 2'(idx - KW'(RADIUS));
        return weights[{tap_dist, 4'b0000} +: 16];
    endfunction

    logic signed [XW-1:0] off_a, off_b;
    logic signed [XW-1:0] p_row, p_col;
    logic [XW:0]          rmap, cmap;
    logic signed [XW-1:0] delta;
    logic signed [SW+1:0] slot_s;
    logic [SW-1:0]        rd_slot;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [23:0]          rd_data;

    assign off_a = center_reg ? '0 : $signed(XW'(ai_reg)) - $signed(XW'(RADIUS));
    assign off_b = center_reg ? '0 : $signed(XW'(bi_reg)) - $signed(XW'(RADIUS));
    assign p_row = $signed(XW'(out_row_reg));
    assign p_col = $signed(XW'(out_col_reg));
    assign rmap  = map_coord(p_row, off_a, $signed(XW'(height_c)), boundary_mode);
    assign cmap  = map_coord(p_col, off_b, $signed(XW'(width_c)), boundary_mode);

    // The mapped row lies within a few lines of the output row, so its ring
    // slot follows from the output slot with one wrap correction.
    assign delta = $signed(rmap[XW-1:0]) - p_row;

    always_comb begin
        slot_s = $signed((SW + 2)'(out_slot_reg)) + $signed((SW + 2)'(delta));
        if (slot_s < 0) begin
            slot_s = slot_s + $signed((SW + 2)'(RING));
        end else if (slot_s >= $signed((SW + 2)'(RING))) begin
            slot_s = slot_s - $signed((SW + 2)'(RING));
        end
        rd_slot = SW'(slot_s);
    end

    assign rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(cmap[CW-1:0]);
    assign wr_addr = AW'(in_slot_reg) * AW'(MAX_WIDTH) + AW'(in_col_reg);

    rum_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (in_pix),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Tap weight product and per-channel accumulation.
    logic [31:0]    wprod_reg;
    logic           tap_ok_reg;
    logic [ACW-1:0] acc_reg [3];
    logic [7:0]     center_pix_reg [3];

    always_ff @(posedge aclk) begin
        if (cmd.addr) begin
            wprod_reg  <= 32'(pick_weight(row_weights, ai_reg))
                        * 32'(pick_weight(col_weights, bi_reg));
            tap_ok_reg <= rmap[XW] && cmap[XW];
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < 3; ch++) begin
            if (cmd.start) begin
                acc_reg[ch] <= '0;
            end else if (cmd.acc) begin
                if (center_reg) begin
                    center_pix_reg[ch] <= tap_ok_reg ? rd_data[16 - 8 * ch +: 8] : 8'd0;
                end else if (tap_ok_reg) begin
                    acc_reg[ch] <= acc_reg[ch]
                        + ACW'(40'(wprod_reg) * 40'(rd_data[16 - 8 * ch +: 8]));
                end
            end
        end
    end

    // Sharpening: subtract the scaled blur, apply the gain, saturate.
    logic [7:0]  blur [3];
    logic [23:0] kprod_reg [3];
    logic [24:0] kround [3];
    logic [7:0]  diff [3];
    logic [31:0] gprod_reg [3];
    logic [32:0] ground [3];
    logic [7:0]  sharp [3];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            blur[ch]   = (|acc_reg[ch][ACW-1:40]) ? 8'hFF : acc_reg[ch][39:32];
            kround[ch] = 25'(kprod_reg[ch]) + 25'd32768;
            diff[ch]   = (9'(center_pix_reg[ch]) > kround[ch][24:16])
                       ? center_pix_reg[ch] - kround[ch][23:16] : 8'd0;
            ground[ch] = 33'(gprod_reg[ch]) + 33'd32768;
            sharp[ch]  = (|ground[ch][32:24]) ? 8'hFF : ground[ch][23:16];
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < 3; ch++) begin
            if (cmd.kb) begin
                kprod_reg[ch] <= 24'(sharpen_k) * 24'(blur[ch]);
            end
            if (cmd.gain) begin
                gprod_reg[ch] <= 32'(out_gain) * 32'(diff[ch]);
            end
        end
    end

    assign out_red   = sharp[0];
    assign out_green = sharp[1];
    assign out_blue  = sharp[2];
    assign frame_end = last_pos;

endmodule

>>> design/rgb_unsharp_mask_filter.sv
// ----------------------------------------------------------------------------
// rgb_unsharp_mask_filter: RGB unsharp mask over a separable Gaussian window
// Pixels enter on the s_ channel in raster order (s_cmd low) or as flush
// beats (s_cmd high); sharpened pixels leave on the m_ channel.
//
// One beat is taken at a time. A beat that releases no output passes
// through ST_CHECK back to ST_IDLE. A beat that releases an output shows
// it on m_valid once all taps are accumulated and the sharpening is done;
// s_ready returns the cycle after the receiver takes it. The line buffer
// memory has a single read port, so taps are read one at a time, each
// addressed in ST_ADDR and accumulated in ST_ACC; two multiply stages
// sharpen. Outputs trail inputs by RADIUS lines and RADIUS pixels; flush
// beats drain the rest of the frame, and a pixel beat sent after the last
// pixel of the frame is dropped but still releases one pending output.
// While m_valid is high and m_ready low the result holds and no beat is
// accepted. Configuration is written through cfg_we/cfg_index/cfg_data
// while the block is idle; the user keeps to this, as the block does not
// enforce it. Reset clears all positions and loads register defaults;
// line memory content is not cleared and is never read unwritten.
// ----------------------------------------------------------------------------
module rgb_unsharp_mask_filter #(
    parameter int RADIUS     = 1,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_in_red,
    input  logic [7:0]  s_in_green,
    input  logic [7:0]  s_in_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic        m_frame_end
);

    logic        boundary_mode_reg;
    logic [47:0] row_weights_reg;
    logic [47:0] col_weights_reg;
    logic [15:0] sharpen_k_reg;
    logic [23:0] out_gain_reg;
    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boundary_mode_reg <= rum_pkg::MODE_ZERO_PAD;
            row_weights_reg   <= '0;
            col_weights_reg   <= '0;
            sharpen_k_reg     <= '0;
            out_gain_reg      <= 24'd65536;
            image_width_reg   <= 11'd512;
            image_height_reg  <= 11'd512;
        end else if (cfg_we) begin
            case (cfg_index)
                rum_pkg::REG_BOUNDARY_MODE: boundary_mode_reg <= cfg_data[0];
                rum_pkg::REG_ROW_WEIGHTS:   row_weights_reg   <= cfg_data;
                rum_pkg::REG_COL_WEIGHTS:   col_weights_reg   <= cfg_data;
                rum_pkg::REG_SHARPEN_K:     sharpen_k_reg     <= cfg_data[15:0];
                rum_pkg::REG_OUT_GAIN:      out_gain_reg      <= cfg_data[23:0];
                rum_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[10:0];
                rum_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[10:0];
                default: begin
                    boundary_mode_reg <= boundary_mode_reg;
                end
            endcase
        end
    end

    rum_pkg::dp_cmd_t    dp_cmd;
    rum_pkg::dp_status_t dp_status;

    rum_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    rum_datapath #(
        .RADIUS     (RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .in_cmd        (s_cmd),
        .in_pix        ({s_in_red, s_in_green, s_in_blue}),
        .boundary_mode (boundary_mode_reg),
        .row_weights   (row_weights_reg),
        .col_weights   (col_weights_reg),
        .sharpen_k     (sharpen_k_reg),
        .out_gain      (out_gain_reg),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .out_red       (m_out_red),
        .out_green     (m_out_green),
        .out_blue      (m_out_blue),
        .frame_end     (m_frame_end)
    );

endmodule
